### rtl/core/orbit_position_statistics_assert.svh
// Assertion macros shared by the orbit position statistics modules.
`ifndef ORBIT_POSITION_STATISTICS_ASSERT_SVH
`define ORBIT_POSITION_STATISTICS_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define OPS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed in %m");

// A condition that must hold in the same cycle as its trigger.
`define OPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// A condition that must hold in the cycle after its trigger.
`define OPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

### rtl/core/ops_pkg.sv
// Types, widths and constants shared by the orbit position statistics modules.
package ops_pkg;

  // Field and store widths.
  localparam int POS_W   = 24;
  localparam int SUM_W   = 34;
  localparam int SQ_W    = 57;
  localparam int COUNT_W = 11;
  localparam int SIG_W   = 24;

  // Readings a set can hold; later readings are dropped.
  localparam int MAX_SAMPLES = 1024;

  // Closing arithmetic: numerator n*S2 - S*S, divisor n*(n-1), variance, root.
  localparam int NUM_W     = 68;
  localparam int DEN_W     = 20;
  localparam int ROOT_W    = 48;
  localparam int MUL_W     = 29;
  localparam int S_LO_W    = SUM_W / 2;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int SQ_CNT_W  = $clog2(ROOT_W / 2);

  // Queue of closed sets between the front and the back.
  localparam int SETQ_DEPTH = 2;
  localparam int SETQ_PTR_W = $clog2(SETQ_DEPTH);
  localparam int SETQ_CNT_W = $clog2(SETQ_DEPTH + 1);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] mean_x;
    logic signed [POS_W-1:0] mean_y;
    logic [SIG_W-1:0]        sigma_x;
    logic [SIG_W-1:0]        sigma_y;
    logic [POS_W-1:0]        peak_x;
    logic [POS_W-1:0]        peak_y;
    logic [COUNT_W-1:0]      sample_count;
    logic                    overflow;
  } result_t;

  // Accumulated statistics of one set.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [SQ_W-1:0]         sumsq_x;
    logic [SQ_W-1:0]         sumsq_y;
    logic [POS_W-1:0]        peak_x;
    logic [POS_W-1:0]        peak_y;
    logic [COUNT_W-1:0]      count;
    logic                    dropped;
  } set_t;

  typedef struct packed {
    logic full;
    logic afull;
    logic empty;
  } setq_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SETUP,
    BK_MEAN,
    BK_MUL,
    BK_VDIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

### rtl/core/ops_front.sv
// Front end: takes readings, squares them and accumulates the open set.
module ops_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ops_pkg::item_t       item,
  input  ops_pkg::setq_status_t q_status,
  output logic                 set_push,
  output ops_pkg::set_t        set_data
);
  import ops_pkg::*;

  `include "orbit_position_statistics_assert.svh"

  logic                    s1_valid;
  logic                    s1_last;
  logic signed [POS_W-1:0] s1_x;
  logic signed [POS_W-1:0] s1_y;
  logic [POS_W-1:0]        s1_mag_x;
  logic [POS_W-1:0]        s1_mag_y;
  logic [2*POS_W-1:0]      s1_sq_x;
  logic [2*POS_W-1:0]      s1_sq_y;
  logic [POS_W-1:0]        mag_x;
  logic [POS_W-1:0]        mag_y;
  set_t                    acc;
  set_t                    acc_next;
  logic                    inflight;
  logic                    stall;
  logic                    accept;
  logic                    room;

  // A closing reading in the stage needs a queue slot before it can move on.
  assign inflight = s1_valid && s1_last;
  assign stall    = inflight && q_status.full;
  assign full     = q_status.full || (inflight && q_status.afull);
  assign accept   = push && !full;

  assign mag_x = item.pos_x[POS_W-1] ? POS_W'(-item.pos_x) : POS_W'(item.pos_x);
  assign mag_y = item.pos_y[POS_W-1] ? POS_W'(-item.pos_y) : POS_W'(item.pos_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last  <= item.last;
      s1_x     <= item.pos_x;
      s1_y     <= item.pos_y;
      s1_mag_x <= mag_x;
      s1_mag_y <= mag_y;
      s1_sq_x  <= item.pos_x * item.pos_x;
      s1_sq_y  <= item.pos_y * item.pos_y;
    end
  end

  always_comb begin
    acc_next = acc;
    room     = acc.count < COUNT_W'(MAX_SAMPLES);
    if (room) begin
      acc_next.sum_x   = acc.sum_x + {{(SUM_W-POS_W){s1_x[POS_W-1]}}, s1_x};
      acc_next.sum_y   = acc.sum_y + {{(SUM_W-POS_W){s1_y[POS_W-1]}}, s1_y};
      acc_next.sumsq_x = acc.sumsq_x + SQ_W'(s1_sq_x);
      acc_next.sumsq_y = acc.sumsq_y + SQ_W'(s1_sq_y);
      if (s1_mag_x > acc.peak_x) begin
        acc_next.peak_x = s1_mag_x;
      end
      if (s1_mag_y > acc.peak_y) begin
        acc_next.peak_y = s1_mag_y;
      end
      acc_next.count = acc.count + 1'b1;
    end else begin
      acc_next.dropped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s1_valid && !stall) begin
      acc <= s1_last ? '0 : acc_next;
    end
  end

  assign set_push = s1_valid && s1_last && !stall;
  assign set_data = acc_next;

  `OPS_ASSERT_IMPL(a_push_has_room, set_push, !q_status.full)

endmodule

### rtl/core/ops_set_fifo.sv
// Short queue of closed sets between the front end and the back end.
module ops_set_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ops_pkg::set_t         data_in,
  input  logic                  pop,
  output ops_pkg::set_t         data_out,
  output ops_pkg::setq_status_t status
);
  import ops_pkg::*;

  `include "orbit_position_statistics_assert.svh"

  set_t                  entries [SETQ_DEPTH];
  logic [SETQ_PTR_W-1:0] wr_ptr;
  logic [SETQ_PTR_W-1:0] rd_ptr;
  logic [SETQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = count == SETQ_CNT_W'(SETQ_DEPTH);
  assign status.afull = count >= SETQ_CNT_W'(SETQ_DEPTH - 1);
  assign status.empty = count == '0;

  assign do_push  = push && !status.full;
  assign do_pop   = pop && !status.empty;
  assign data_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == SETQ_PTR_W'(SETQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == SETQ_PTR_W'(SETQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `OPS_ASSERT_ALWAYS(a_count_bounded, count <= SETQ_CNT_W'(SETQ_DEPTH))
  `OPS_ASSERT_NEXT(a_push_grows, !rst && do_push && !do_pop, count == $past(count) + 1'b1)

endmodule

### rtl/core/ops_back.sv
// Back end: divides, multiplies and takes square roots to close each set.
module ops_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ops_pkg::set_t         q_data,
  input  ops_pkg::setq_status_t q_status,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output ops_pkg::result_t      result
);
  import ops_pkg::*;

  `include "orbit_position_statistics_assert.svh"

  // Partial products of n*S2 - S*S, issued one per cycle.
  localparam logic [2:0] MS_NS2_LO = 3'd0;
  localparam logic [2:0] MS_NS2_HI = 3'd1;
  localparam logic [2:0] MS_SS_LL  = 3'd2;
  localparam logic [2:0] MS_SS_LH  = 3'd3;
  localparam logic [2:0] MS_SS_HH  = 3'd4;
  localparam logic [2:0] MS_DRAIN  = 3'd5;

  back_state_t state;
  back_state_t state_next;

  set_t                    st;
  logic                    plane;
  logic [DEN_W-1:0]        den;
  logic [2*COUNT_W-1:0]    den_full;
  logic signed [POS_W-1:0] mean_x;
  logic signed [POS_W-1:0] mean_y;
  logic [SIG_W-1:0]        sigma_x;
  logic [SIG_W-1:0]        sigma_y;
  result_t                 res;
  logic                    res_valid;
  logic                    res_load;

  logic signed [SUM_W-1:0] s_sel;
  logic [SQ_W-1:0]         s2_sel;
  logic [SUM_W-1:0]        s_mag;
  logic [MUL_W-1:0]        m_lo;
  logic [MUL_W-1:0]        m_hi;
  logic                    few;

  // Shared restoring divider.
  logic [DEN_W-1:0]     dv_rem;
  logic [NUM_W-1:0]     dv_quo;
  logic [DEN_W-1:0]     dv_den;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic [DEN_W:0]       dv_trial;
  logic                 dv_ge;
  logic [DEN_W-1:0]     dv_rem_next;
  logic [NUM_W-1:0]     dv_quo_next;
  logic                 dv_last;
  logic [POS_W-1:0]     q_mag;
  logic [POS_W-1:0]     mean_val;

  // Multiply and accumulate.
  logic [2:0]           mk;
  logic [2:0]           pk;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [2*MUL_W-1:0]   prod;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     num_next;
  logic [NUM_W-1:0]     term;
  logic                 term_add;

  // Bitwise integer square root.
  logic [ROOT_W-1:0]    sq_v;
  logic [ROOT_W-1:0]    sq_res;
  logic [ROOT_W-1:0]    sq_bit;
  logic [SQ_CNT_W-1:0]  sq_cnt;
  logic [ROOT_W-1:0]    sq_trial;
  logic                 sq_ge;
  logic [ROOT_W-1:0]    sq_res_next;
  logic                 sq_last;

  assign s_sel  = plane ? st.sum_y : st.sum_x;
  assign s2_sel = plane ? st.sumsq_y : st.sumsq_x;
  assign s_mag  = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
  assign m_lo   = MUL_W'(s_mag[S_LO_W-1:0]);
  assign m_hi   = MUL_W'(s_mag[SUM_W-1:S_LO_W]);
  assign few    = st.count < COUNT_W'(2);

  assign den_full = (2*COUNT_W)'(st.count) * (2*COUNT_W)'(st.count - 1'b1);

  assign dv_trial    = {dv_rem, dv_quo[NUM_W-1]};
  assign dv_ge       = dv_trial >= {1'b0, dv_den};
  assign dv_rem_next = dv_ge ? DEN_W'(dv_trial - {1'b0, dv_den}) : DEN_W'(dv_trial);
  assign dv_quo_next = {dv_quo[NUM_W-2:0], dv_ge};
  assign dv_last     = dv_cnt == DIV_CNT_W'(NUM_W - 1);
  assign q_mag       = dv_quo_next[POS_W-1:0];
  assign mean_val    = s_sel[SUM_W-1] ? POS_W'(-q_mag) : q_mag;

  assign sq_trial    = sq_res + sq_bit;
  assign sq_ge       = sq_v >= sq_trial;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  assign sq_last     = sq_cnt == SQ_CNT_W'(ROOT_W / 2 - 1);

  always_comb begin
    case (mk)
      MS_NS2_LO: begin
        mul_a = MUL_W'(st.count);
        mul_b = s2_sel[MUL_W-1:0];
      end
      MS_NS2_HI: begin
        mul_a = MUL_W'(st.count);
        mul_b = MUL_W'(s2_sel[SQ_W-1:MUL_W]);
      end
      MS_SS_LL: begin
        mul_a = m_lo;
        mul_b = m_lo;
      end
      MS_SS_LH: begin
        mul_a = m_lo;
        mul_b = m_hi;
      end
      MS_SS_HH: begin
        mul_a = m_hi;
        mul_b = m_hi;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The cross term appears twice in S*S, hence the extra shift.
  always_comb begin
    case (pk)
      MS_NS2_LO: begin
        term     = NUM_W'(prod);
        term_add = 1'b1;
      end
      MS_NS2_HI: begin
        term     = NUM_W'(prod) << MUL_W;
        term_add = 1'b1;
      end
      MS_SS_LL: begin
        term     = NUM_W'(prod);
        term_add = 1'b0;
      end
      MS_SS_LH: begin
        term     = NUM_W'(prod) << (S_LO_W + 1);
        term_add = 1'b0;
      end
      MS_SS_HH: begin
        term     = NUM_W'(prod) << (2 * S_LO_W);
        term_add = 1'b0;
      end
      default: begin
        term     = '0;
        term_add = 1'b1;
      end
    endcase
  end

  assign num_next = (mk == MS_NS2_LO) ? num : (term_add ? num + term : num - term);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (!q_status.empty) state_next = BK_SETUP;
      BK_SETUP: state_next = BK_MEAN;
      BK_MEAN:  if (dv_last) state_next = BK_MUL;
      BK_MUL: begin
        if (mk == MS_DRAIN) begin
          if (!few) begin
            state_next = BK_VDIV;
          end else begin
            state_next = plane ? BK_DONE : BK_SETUP;
          end
        end
      end
      BK_VDIV:  if (dv_last) state_next = BK_SQRT;
      BK_SQRT:  if (sq_last) state_next = plane ? BK_DONE : BK_SETUP;
      BK_DONE:  if (!res_valid || pop) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    unique case (state)
      BK_IDLE: q_pop    = !q_status.empty;
      BK_DONE: res_load = !res_valid || pop;
      default: begin
        q_pop    = 1'b0;
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (q_pop) begin
          st    <= q_data;
          plane <= 1'b0;
        end
      end
      BK_SETUP: begin
        den    <= den_full[DEN_W-1:0];
        dv_quo <= NUM_W'(s_mag);
        dv_rem <= '0;
        dv_cnt <= '0;
        dv_den <= DEN_W'(st.count);
      end
      BK_MEAN: begin
        dv_quo <= dv_quo_next;
        dv_rem <= dv_rem_next;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          if (plane) begin
            mean_y <= mean_val;
          end else begin
            mean_x <= mean_val;
          end
          mk  <= MS_NS2_LO;
          num <= '0;
        end
      end
      BK_MUL: begin
        prod <= mul_a * mul_b;
        pk   <= mk;
        num  <= num_next;
        mk   <= mk + 1'b1;
        if (mk == MS_DRAIN) begin
          dv_quo <= num_next;
          dv_rem <= '0;
          dv_cnt <= '0;
          dv_den <= den;
          if (few) begin
            if (plane) begin
              sigma_y <= '0;
            end else begin
              sigma_x <= '0;
            end
            plane <= ~plane;
          end
        end
      end
      BK_VDIV: begin
        dv_quo <= dv_quo_next;
        dv_rem <= dv_rem_next;
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          sq_v   <= dv_quo_next[ROOT_W-1:0];
          sq_res <= '0;
          sq_bit <= ROOT_W'(1) << (ROOT_W - 2);
          sq_cnt <= '0;
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          sq_v <= sq_v - sq_trial;
        end
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_last) begin
          if (plane) begin
            sigma_y <= sq_res_next[SIG_W-1:0];
          end else begin
            sigma_x <= sq_res_next[SIG_W-1:0];
          end
          plane <= ~plane;
        end
      end
      BK_DONE: begin
        if (res_load) begin
          res.mean_x       <= mean_x;
          res.mean_y       <= mean_y;
          res.sigma_x      <= sigma_x;
          res.sigma_y      <= sigma_y;
          res.peak_x       <= st.peak_x;
          res.peak_y       <= st.peak_y;
          res.sample_count <= st.count;
          res.overflow     <= st.dropped;
        end
      end
      default: begin
        plane <= 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  assign empty  = !res_valid;
  assign result = res;

  `OPS_ASSERT_IMPL(a_count_nonzero, res_valid, res.sample_count != '0)
  `OPS_ASSERT_IMPL(a_single_sigma, res_valid && res.sample_count == COUNT_W'(1),
                   res.sigma_x == '0 && res.sigma_y == '0)

endmodule

### rtl/core/orbit_position_statistics.sv
// Top level of the orbit position statistics block.
// Each item is one beam position monitor reading (signed horizontal and
// vertical positions in nanometres and a last flag). Readings are summed,
// squared and peak-tracked per plane at one item per cycle; the item with
// last set closes the set and yields one result: the mean truncated toward
// zero, the floored sample standard deviation (zero for a single reading),
// the peak magnitude, the reading count and an overflow flag that is set
// when readings beyond 1024 were dropped. Both sides behave as queues: an
// item enters when push is high and full is low, and a result leaves when
// pop is high and empty is low. The input is held off while two closed sets
// wait in the queue, and also while one waits and a closing item sits in the
// front stage; otherwise readings flow at one per cycle. Closing a set runs
// through one shared divider, one 29 by 29 multiplier and one square root
// unit, plane after plane: per plane a setup step, the mean division, the
// variance numerator, the variance division and the square root; a set of
// a single reading skips the variance division and the square root. A
// result waits in its output register while the back end already works on
// the next queued set.
module orbit_position_statistics (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ops_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output ops_pkg::result_t result
);
  import ops_pkg::*;

  // Closed sets travel from the front end to the back end through this queue.
  logic         set_push;
  set_t         set_data;
  set_t         q_data;
  logic         q_pop;
  setq_status_t q_status;

  ops_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .q_status (q_status),
    .set_push (set_push),
    .set_data (set_data)
  );

  ops_set_fifo u_set_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (set_push),
    .data_in  (set_data),
    .pop      (q_pop),
    .data_out (q_data),
    .status   (q_status)
  );

  ops_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_data),
    .q_status (q_status),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
